FILE: hw/rtl/shbh_pkg.sv
`timescale 1ns / 1ps

package shbh_pkg;

  localparam int DEFAULT_TABLE_DEPTH       = 2048;
  localparam int DEFAULT_RECORD_INDEX_BITS = 24;

  localparam int KEY_BYTE_W     = 8;
  localparam int BUCKET_W       = 11;
  localparam int PREV_HEAD_W    = 25;
  localparam int RECORD_INDEX_W = 24;

  localparam int HASH_BASE_W    = 16;
  localparam int BUCKET_COUNT_W = 12;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 2;

  // Multiplier operand of the serial modular multiply unit, scanned MSB first.
  localparam int OP_W   = 16;
  localparam int STEP_W = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_HASH_BASE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_COUNT = 2'd1;

  localparam logic [HASH_BASE_W-1:0]    HASH_BASE_RESET    = 16'd167;
  localparam logic [BUCKET_COUNT_W-1:0] BUCKET_COUNT_RESET = 12'd1801;

  localparam logic [KEY_BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

  localparam logic [STEP_W-1:0] STEPS_BYTE = 5'd8;
  localparam logic [STEP_W-1:0] STEPS_BASE = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_MULT,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } mm_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

FILE: hw/rtl/shbh_in_if.sv
`timescale 1ns / 1ps

interface shbh_in_if;
  logic                              valid;
  logic                              ready;
  logic [shbh_pkg::KEY_BYTE_W-1:0]   key_byte;
  logic                              last;

  modport source (output valid, output key_byte, output last, input ready);
  modport sink   (input valid, input key_byte, input last, output ready);
endinterface

FILE: hw/rtl/shbh_out_if.sv
`timescale 1ns / 1ps

interface shbh_out_if;
  logic                                     valid;
  logic                                     ready;
  logic        [shbh_pkg::BUCKET_W-1:0]       bucket;
  logic signed [shbh_pkg::PREV_HEAD_W-1:0]    previous_head;
  logic        [shbh_pkg::RECORD_INDEX_W-1:0] record_index;

  modport source (output valid, output bucket, output previous_head, output record_index,
                  input ready);
  modport sink   (input valid, input bucket, input previous_head, input record_index,
                  output ready);
endinterface

FILE: hw/rtl/shbh_modmul.sv
`timescale 1ns / 1ps

// Serial modular multiply: one multiplier bit per cycle, MSB first.
// The accumulator stays below the modulus after every step, so each step is
// a doubling and an add, each followed by at most one subtract.
module shbh_modmul #(
  parameter int AW = 11,
  parameter int MW = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  shbh_pkg::mm_ctrl_t        ctrl,
  input  logic [MW-1:0]             modulus,
  input  logic [AW-1:0]             multiplicand,
  input  logic [shbh_pkg::OP_W-1:0] multiplier,
  output shbh_pkg::mm_stat_t        stat,
  output logic [AW-1:0]             product
);

  localparam int XW = MW + 1;

  logic                        busy;
  logic                        done;
  logic [shbh_pkg::STEP_W-1:0] count;
  logic [AW-1:0]               acc;
  logic [AW-1:0]               a_reg;
  logic [shbh_pkg::OP_W-1:0]   op_reg;

  logic [XW-1:0] dbl;
  logic [XW-1:0] dbl_red;
  logic [XW-1:0] sum;
  logic [XW-1:0] sum_red;

  always_comb begin
    dbl     = XW'(acc) << 1;
    dbl_red = (dbl >= XW'(modulus)) ? dbl - XW'(modulus) : dbl;
    sum     = dbl_red + (op_reg[shbh_pkg::OP_W-1] ? XW'(a_reg) : XW'(0));
    sum_red = (sum >= XW'(modulus)) ? sum - XW'(modulus) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (ctrl.start) begin
      busy   <= 1'b1;
      done   <= 1'b0;
      count  <= ctrl.steps;
      acc    <= '0;
      a_reg  <= multiplicand;
      op_reg <= multiplier;
    end else if (busy) begin
      acc    <= AW'(sum_red);
      op_reg <= op_reg << 1;
      count  <= count - 1'b1;
      if (count == shbh_pkg::STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = acc;

endmodule

FILE: hw/rtl/shbh_head_mem.sv
`timescale 1ns / 1ps

// Bucket head table: one write port, one read port with registered data.
module shbh_head_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 25
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/string_hash_bucket_head_insert.sv
`timescale 1ns / 1ps

// Polynomial string hash with chained-table head insert.
// keys carries one key byte per word, with last marking the final byte of a
// key. results carries one word per finished key: the bucket, the record that
// headed that bucket before (all ones if it was empty) and the new record
// index, which becomes the bucket's head. cfg_we/cfg_index/cfg_data write
// hash_base (index 0) and bucket_count (index 1); other indexes are ignored.
// Flow: the next byte is accepted only once the serial modular multiply of
// the running power by all 16 bits of hash_base finishes (the byte product
// runs in a second unit alongside it). The first byte after reset or a
// bucket_count write first reduces the running sum and power by the current
// modulus. A last byte then reads the head table before its result is
// registered. After reset the head table is cleared to empty, one entry a
// cycle, while keys.ready stays low.
// The result sits in an output register; new bytes are taken while it waits.
// A finished key stalls only if the previous result has not yet been taken.
module string_hash_bucket_head_insert #(
  parameter int TABLE_DEPTH       = shbh_pkg::DEFAULT_TABLE_DEPTH,
  parameter int RECORD_INDEX_BITS = shbh_pkg::DEFAULT_RECORD_INDEX_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [shbh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [shbh_pkg::CFG_DATA_W-1:0]  cfg_data,
  shbh_in_if.sink                          keys,
  shbh_out_if.source                       results
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int MW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = MW + 1;
  localparam int DW = RECORD_INDEX_BITS + 1;

  shbh_pkg::state_t state;
  shbh_pkg::state_t state_next;

  logic [shbh_pkg::HASH_BASE_W-1:0]    hash_base;
  logic [shbh_pkg::BUCKET_COUNT_W-1:0] bucket_count;
  logic                                stale;
  logic [AW-1:0]                       running_sum;
  logic [AW-1:0]                       running_power;
  logic [RECORD_INDEX_BITS-1:0]        record_counter;
  logic [shbh_pkg::KEY_BYTE_W-1:0]     byte_reg;
  logic                                last_reg;
  logic [AW-1:0]                       bucket_reg;
  logic [AW-1:0]                       clr_addr;

  logic                                    out_valid;
  logic [shbh_pkg::BUCKET_W-1:0]           out_bucket;
  logic signed [shbh_pkg::PREV_HEAD_W-1:0] out_prev;
  logic [shbh_pkg::RECORD_INDEX_W-1:0]     out_index;

  logic [MW-1:0] m;
  logic [AW-1:0] one_m;
  logic [XW-1:0] sum_raw;
  logic [XW-1:0] sum_red;

  shbh_pkg::mm_ctrl_t        u0_ctrl;
  shbh_pkg::mm_ctrl_t        u1_ctrl;
  shbh_pkg::mm_stat_t        u0_stat;
  shbh_pkg::mm_stat_t        u1_stat;
  logic [AW-1:0]             u0_a;
  logic [AW-1:0]             u1_a;
  logic [shbh_pkg::OP_W-1:0] u0_op;
  logic [shbh_pkg::OP_W-1:0] u1_op;
  logic [AW-1:0]             u0_product;
  logic [AW-1:0]             u1_product;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [DW-1:0] mem_rdata;

  logic keys_ready;
  logic accept;
  logic reduce_done;
  logic step_done;
  logic out_load;

  // Effective modulus: zero counts as one, and it never exceeds the table.
  always_comb begin
    if (bucket_count == '0) begin
      m = MW'(1);
    end else if (32'(bucket_count) > 32'(TABLE_DEPTH)) begin
      m = MW'(TABLE_DEPTH);
    end else begin
      m = MW'(bucket_count);
    end
    one_m = (m == MW'(1)) ? AW'(0) : AW'(1);
  end

  always_comb begin
    sum_raw = XW'(running_sum) + ((byte_reg == shbh_pkg::NEWLINE_BYTE) ? XW'(0)
                                                                       : XW'(u0_product));
    sum_red = (sum_raw >= XW'(m)) ? sum_raw - XW'(m) : sum_raw;
  end

  assign accept = keys.valid && keys_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shbh_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    keys_ready  = 1'b0;
    u0_ctrl     = '0;
    u1_ctrl     = '0;
    u0_a        = running_power;
    u1_a        = running_power;
    u0_op       = {byte_reg, 8'h00};
    u1_op       = hash_base;
    mem_we      = 1'b0;
    mem_waddr   = clr_addr;
    mem_wdata   = {1'b1, {RECORD_INDEX_BITS{1'b0}}};
    mem_re      = 1'b0;
    reduce_done = 1'b0;
    step_done   = 1'b0;
    out_load    = 1'b0;
    case (state)
      shbh_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
          state_next = shbh_pkg::ST_IDLE;
        end
      end
      shbh_pkg::ST_IDLE: begin
        keys_ready = 1'b1;
        if (keys.valid) begin
          if (stale) begin
            // Reset or a modulus change came since the running values were stored.
            u0_ctrl.start = 1'b1;
            u0_ctrl.steps = shbh_pkg::STEP_W'(AW);
            u0_a          = one_m;
            u0_op         = shbh_pkg::OP_W'(running_sum) << (shbh_pkg::OP_W - AW);
            u1_ctrl.start = 1'b1;
            u1_ctrl.steps = shbh_pkg::STEP_W'(AW);
            u1_a          = one_m;
            u1_op         = shbh_pkg::OP_W'(running_power) << (shbh_pkg::OP_W - AW);
            state_next    = shbh_pkg::ST_REDUCE;
          end else begin
            u0_ctrl.start = 1'b1;
            u0_ctrl.steps = shbh_pkg::STEPS_BYTE;
            u0_op         = {keys.key_byte, 8'h00};
            u1_ctrl.start = 1'b1;
            u1_ctrl.steps = shbh_pkg::STEPS_BASE;
            state_next    = shbh_pkg::ST_MULT;
          end
        end
      end
      shbh_pkg::ST_REDUCE: begin
        if (u1_stat.done) begin
          reduce_done   = 1'b1;
          u0_ctrl.start = 1'b1;
          u0_ctrl.steps = shbh_pkg::STEPS_BYTE;
          u0_a          = u1_product;
          u1_ctrl.start = 1'b1;
          u1_ctrl.steps = shbh_pkg::STEPS_BASE;
          u1_a          = u1_product;
          state_next    = shbh_pkg::ST_MULT;
        end
      end
      shbh_pkg::ST_MULT: begin
        if (u1_stat.done) begin
          step_done = 1'b1;
          if (last_reg) begin
            mem_re     = 1'b1;
            state_next = shbh_pkg::ST_LOOKUP;
          end else begin
            state_next = shbh_pkg::ST_IDLE;
          end
        end
      end
      shbh_pkg::ST_LOOKUP: begin
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          mem_we     = 1'b1;
          mem_waddr  = bucket_reg;
          mem_wdata  = {1'b0, record_counter};
          state_next = shbh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = shbh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr       <= '0;
      hash_base      <= shbh_pkg::HASH_BASE_RESET;
      bucket_count   <= shbh_pkg::BUCKET_COUNT_RESET;
      stale          <= 1'b1;
      running_sum    <= '0;
      running_power  <= AW'(1);
      record_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == shbh_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        byte_reg <= keys.key_byte;
        last_reg <= keys.last;
      end
      if (reduce_done) begin
        running_sum   <= u0_product;
        running_power <= u1_product;
        stale         <= 1'b0;
      end
      if (step_done) begin
        if (last_reg) begin
          bucket_reg    <= AW'(sum_red);
          running_sum   <= '0;
          // Kept as a plain one; a later modulus change reduces it afresh.
          running_power <= AW'(1);
        end else begin
          running_sum   <= AW'(sum_red);
          running_power <= u1_product;
        end
      end
      if (out_load) begin
        out_valid      <= 1'b1;
        out_bucket     <= shbh_pkg::BUCKET_W'(bucket_reg);
        out_prev       <= mem_rdata[DW-1] ? '1
                                          : shbh_pkg::PREV_HEAD_W'(
                                              mem_rdata[RECORD_INDEX_BITS-1:0]);
        out_index      <= shbh_pkg::RECORD_INDEX_W'(record_counter);
        record_counter <= record_counter + 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          shbh_pkg::REG_HASH_BASE: begin
            hash_base <= shbh_pkg::HASH_BASE_W'(cfg_data);
          end
          shbh_pkg::REG_BUCKET_COUNT: begin
            bucket_count <= shbh_pkg::BUCKET_COUNT_W'(cfg_data);
            stale        <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  shbh_modmul #(.AW(AW), .MW(MW)) u_mul_byte (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (u0_ctrl),
    .modulus      (m),
    .multiplicand (u0_a),
    .multiplier   (u0_op),
    .stat         (u0_stat),
    .product      (u0_product)
  );

  shbh_modmul #(.AW(AW), .MW(MW)) u_mul_base (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (u1_ctrl),
    .modulus      (m),
    .multiplicand (u1_a),
    .multiplier   (u1_op),
    .stat         (u1_stat),
    .product      (u1_product)
  );

  shbh_head_mem #(.DEPTH(TABLE_DEPTH), .AW(AW), .DW(DW)) u_head_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (AW'(sum_red)),
    .rdata (mem_rdata)
  );

  assign keys.ready            = keys_ready;
  assign results.valid         = out_valid;
  assign results.bucket        = out_bucket;
  assign results.previous_head = out_prev;
  assign results.record_index  = out_index;

  // A byte in flight blocks the next one until its multiply finishes.
  a_one_byte_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !keys.ready)
    else $error("byte accepted while another is in progress");

  // Both reductions run the same number of steps and must finish together.
  a_reduce_in_step: assert property (@(posedge clk) disable iff (rst)
    (state == shbh_pkg::ST_REDUCE && u1_stat.done) |-> u0_stat.done)
    else $error("running sum reduction not finished with power reduction");

  // The bucket looked up must lie inside the buckets in use.
  a_bucket_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == shbh_pkg::ST_LOOKUP) |-> (MW'(bucket_reg) < m))
    else $error("bucket outside the modulus");

endmodule

FILE: tb/sv/string_hash_bucket_head_insert_test.sv
`timescale 1ns / 1ps

module string_hash_bucket_head_insert_test;

  localparam int TABLE_DEPTH     = shbh_pkg::DEFAULT_TABLE_DEPTH;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int SETTLE          = 40;
  localparam int PHASES          = 8;
  localparam int BYTES_PER_PHASE = 125;
  localparam int PLAN_ROWS       = 31;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [shbh_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [shbh_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic        [shbh_pkg::BUCKET_W-1:0]       bucket;
    logic signed [shbh_pkg::PREV_HEAD_W-1:0]    previous_head;
    logic        [shbh_pkg::RECORD_INDEX_W-1:0] record_index;
  } head_insert_t;

  typedef enum logic {DO_BYTE, DO_CFG} step_t;

  typedef struct packed {
    step_t                            kind;
    logic [shbh_pkg::CFG_INDEX_W-1:0] addr;
    logic [shbh_pkg::CFG_DATA_W-1:0]  data;
    logic                             last;
    logic                             typed;
    head_insert_t                     want;
  } plan_row_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [shbh_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [shbh_pkg::CFG_DATA_W-1:0]  cfg_data;

  shbh_in_if  keys_if ();
  shbh_out_if results_if ();

  string_hash_bucket_head_insert u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys_if.sink),
    .results   (results_if.source)
  );

  always #5 clk = ~clk;

  // Mirror of the block's registers and hash state.
  logic [shbh_pkg::HASH_BASE_W-1:0]    base_reg  = shbh_pkg::HASH_BASE_RESET;
  logic [shbh_pkg::BUCKET_COUNT_W-1:0] count_reg = shbh_pkg::BUCKET_COUNT_RESET;
  int unsigned                         run_sum   = 0;
  int unsigned                         run_power = 1;
  logic [shbh_pkg::RECORD_INDEX_W-1:0] next_record = '0;
  bit                                  occupied [TABLE_DEPTH];
  logic [shbh_pkg::RECORD_INDEX_W-1:0] head_of  [TABLE_DEPTH];

  head_insert_t head_inserts[$];
  int           mismatches = 0;
  int           cycles = 0;
  int           rx_hold = 0;
  bit           calm = 1'b0;

  // Directed keys. The first five rows start from the reset state, so their
  // buckets and heads can be read straight off the bytes.
  plan_row_t plan [PLAN_ROWS] = '{
    '{DO_BYTE, '0, 16'd0,   1'b1, 1'b1, '{11'd0,   -25'sd1, 24'd0}},
    '{DO_BYTE, '0, 16'd0,   1'b1, 1'b1, '{11'd0,    25'sd0, 24'd1}},
    '{DO_BYTE, '0, 16'd1,   1'b1, 1'b1, '{11'd1,   -25'sd1, 24'd2}},
    '{DO_BYTE, '0, 16'd255, 1'b1, 1'b1, '{11'd255, -25'sd1, 24'd3}},
    '{DO_BYTE, '0, 16'd10,  1'b1, 1'b1, '{11'd0,    25'sd1, 24'd4}},
    '{DO_BYTE, '0, 16'd255, 1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd10,  1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd128, 1'b1, 1'b0, '0},
    '{DO_CFG,  shbh_pkg::REG_HASH_BASE,    16'hFFFF, 1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd97,  1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd255, 1'b1, 1'b0, '0},
    '{DO_CFG,  shbh_pkg::REG_BUCKET_COUNT, 16'd2048, 1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd200, 1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd77,  1'b1, 1'b0, '0},
    '{DO_CFG,  shbh_pkg::REG_BUCKET_COUNT, 16'hFFFF, 1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd1,   1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd255, 1'b1, 1'b0, '0},
    '{DO_CFG,  shbh_pkg::REG_BUCKET_COUNT, 16'hF000, 1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd5,   1'b1, 1'b0, '0},
    '{DO_CFG,  shbh_pkg::REG_HASH_BASE,    16'd0,    1'b0, 1'b0, '0},
    '{DO_CFG,  shbh_pkg::REG_BUCKET_COUNT, 16'd3,    1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd3,   1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd9,   1'b1, 1'b0, '0},
    '{DO_CFG,  shbh_pkg::REG_HASH_BASE,    16'd1,    1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd254, 1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd7,   1'b1, 1'b0, '0},
    '{DO_CFG,  REG_SPARE_2,                16'h0001, 1'b0, 1'b0, '0},
    '{DO_CFG,  REG_SPARE_3,                16'hFFFF, 1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd100, 1'b0, 1'b0, '0},
    '{DO_CFG,  shbh_pkg::REG_BUCKET_COUNT, 16'd97,   1'b0, 1'b0, '0},
    '{DO_BYTE, '0, 16'd50,  1'b1, 1'b0, '0}
  };

  // Folds one key byte into the running hash. Returns 1 when the byte ends a
  // key, with the head insert that the block should report.
  function automatic logic hash_byte(input logic [shbh_pkg::KEY_BYTE_W-1:0] b,
                                     input logic fin, output head_insert_t r);
    int unsigned m;
    int unsigned s;
    int unsigned p;
    m = count_reg;
    if (m == 0) m = 1;
    if (m > TABLE_DEPTH) m = TABLE_DEPTH;
    // The state is reduced again on use, since the modulus may have changed.
    s = run_sum % m;
    p = run_power % m;
    if (b != shbh_pkg::NEWLINE_BYTE) s = (s + (int'(b) * p) % m) % m;
    p = (p * int'(base_reg)) % m;
    r = '0;
    if (!fin) begin
      run_sum = s;
      run_power = p;
      return 1'b0;
    end
    r.bucket = s[shbh_pkg::BUCKET_W-1:0];
    r.previous_head = occupied[s] ? {1'b0, head_of[s]} : '1;
    r.record_index = next_record;
    head_of[s] = next_record;
    occupied[s] = 1'b1;
    next_record = next_record + 1'b1;
    run_sum = 0;
    run_power = 1;
    return 1'b1;
  endfunction

  function automatic logic [shbh_pkg::CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return shbh_pkg::CFG_DATA_W'($urandom_range(0, 1));
      1: return shbh_pkg::CFG_DATA_W'(TABLE_DEPTH);
      2: return shbh_pkg::CFG_DATA_W'($urandom_range(2049, 65535));
      3: return shbh_pkg::CFG_DATA_W'($urandom_range(0, 65535));
      default: return shbh_pkg::CFG_DATA_W'($urandom_range(2, 64));
    endcase
  endfunction

  task automatic send_byte(input logic [shbh_pkg::KEY_BYTE_W-1:0] b, input logic fin,
                           input logic typed, input head_insert_t typed_want);
    head_insert_t got;
    if (!calm && $urandom_range(0, 7) == 0) begin
      keys_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    keys_if.valid <= 1'b1;
    keys_if.key_byte <= b;
    keys_if.last <= fin;
    @(posedge clk);
    while (!keys_if.ready) @(posedge clk);
    if (hash_byte(b, fin, got)) head_inserts.push_back(typed ? typed_want : got);
  endtask

  task automatic drain();
    keys_if.valid <= 1'b0;
    while (head_inserts.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [shbh_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [shbh_pkg::CFG_DATA_W-1:0] value);
    drain();
    // A byte that ends no key may still be in the multiplier.
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == shbh_pkg::REG_HASH_BASE) base_reg = value;
    else if (idx == shbh_pkg::REG_BUCKET_COUNT)
      count_reg = value[shbh_pkg::BUCKET_COUNT_W-1:0];
  endtask

  task automatic check_result();
    head_insert_t want;
    if (head_inserts.size() == 0) begin
      $error("result word with nothing pending: bucket %0d, previous_head %0d, record_index %0d",
             results_if.bucket, results_if.previous_head, results_if.record_index);
      mismatches++;
      return;
    end
    want = head_inserts.pop_front();
    if (results_if.bucket !== want.bucket) begin
      $error("bucket: expected %0d, got %0d", want.bucket, results_if.bucket);
      mismatches++;
    end
    if (results_if.previous_head !== want.previous_head) begin
      $error("previous_head: expected %0d, got %0d", want.previous_head,
             results_if.previous_head);
      mismatches++;
    end
    if (results_if.record_index !== want.record_index) begin
      $error("record_index: expected %0d, got %0d", want.record_index,
             results_if.record_index);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (results_if.valid && results_if.ready) check_result();
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      results_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      rx_hold <= $urandom_range(0, 10);
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int len;
    int sent;
    bit paused;
    logic [shbh_pkg::KEY_BYTE_W-1:0] b;
    logic [shbh_pkg::CFG_DATA_W-1:0] base_pick;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    keys_if.valid <= 1'b0;
    keys_if.key_byte <= '0;
    keys_if.last <= 1'b0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == DO_CFG) write_register(plan[r].addr, plan[r].data);
      else send_byte(plan[r].data[shbh_pkg::KEY_BYTE_W-1:0], plan[r].last, plan[r].typed,
                     plan[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == PHASES - 1);
      case ($urandom_range(0, 4))
        0: base_pick = shbh_pkg::CFG_DATA_W'($urandom_range(0, 1));
        1: base_pick = 16'hFFFF;
        2: base_pick = 16'd2;
        default: base_pick = shbh_pkg::CFG_DATA_W'($urandom_range(0, 65535));
      endcase
      write_register(shbh_pkg::REG_HASH_BASE, base_pick);
      write_register(shbh_pkg::REG_BUCKET_COUNT, pick_count());
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        // Mostly short keys; now and then a long one to wrap the power.
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          b = ($urandom_range(0, 7) == 0) ? shbh_pkg::NEWLINE_BYTE
                                          : shbh_pkg::KEY_BYTE_W'($urandom_range(0, 255));
          send_byte(b, i == len - 1, 1'b0, '0);
          sent++;
          if (i == 0 && len > 1 && $urandom_range(0, 39) == 0)
            write_register(shbh_pkg::REG_BUCKET_COUNT, pick_count());
        end
        if (ph == 3 && !paused && sent >= 60) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
